/* hdl/dxt1_pkg.sv */
package dxt1_pkg;

    // Configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam int CFG_W     = 13;   // width of one configuration register
    localparam int CNT_W     = 10;   // block column / row counter width
    localparam int BLK_W     = 11;   // block count, holds up to 1024
    localparam int COORD_W   = 12;   // pixel coordinate width
    localparam int CHAN_W    = 8;    // one expanded color channel
    localparam int NUM_CHAN  = 3;    // red, green, blue lanes
    localparam int NUM_PIX   = 16;   // pixels per block

    localparam logic [BLK_W-1:0]  BLK_LIMIT   = 11'd1024;
    localparam logic [CFG_W-1:0]  DIM_RESET   = 13'd256;
    localparam logic [7:0]        ALPHA_OPAQUE = 8'hFF;
    // reciprocal of three scaled by 2^11, exact for sums up to 765
    localparam logic [9:0]        RECIP3      = 10'd683;

    typedef struct packed {
        logic [15:0] color0;
        logic [15:0] color1;
        logic [31:0] index_bits;
    } t_in_item;

    typedef struct packed {
        logic [31:0]        pixel_argb;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               last_of_block;
        logic               last_of_image;
    } t_out_item;

    // per-lane end colors and the blend mode
    typedef struct packed {
        logic [CHAN_W-1:0] end0;
        logic [CHAN_W-1:0] end1;
        logic              opaque;
    } t_lane_in;

    typedef struct packed {
        logic [CHAN_W-1:0] mid2;
        logic [CHAN_W-1:0] mid3;
    } t_lane_out;

    typedef logic [3:0][31:0] t_palette;

endpackage

/* hdl/dxt1_lane.sv */
// One color channel: derives palette entries two and three from the end colors.
module dxt1_lane
    import dxt1_pkg::*;
(
    input  t_lane_in  i_lane,
    output t_lane_out o_lane
);

    logic [9:0]  sum_a;      // 2*end0 + end1
    logic [9:0]  sum_b;      // end0 + 2*end1
    logic [19:0] prod_a;
    logic [19:0] prod_b;
    logic [8:0]  sum_avg;

    assign sum_a   = {1'b0, i_lane.end0, 1'b0} + {2'b00, i_lane.end1};
    assign sum_b   = {2'b00, i_lane.end0} + {1'b0, i_lane.end1, 1'b0};
    assign prod_a  = sum_a * RECIP3;
    assign prod_b  = sum_b * RECIP3;
    assign sum_avg = {1'b0, i_lane.end0} + {1'b0, i_lane.end1};

    always_comb begin
        if (i_lane.opaque) begin
            o_lane.mid2 = prod_a[18:11];
            o_lane.mid3 = prod_b[18:11];
        end else begin
            o_lane.mid2 = sum_avg[8:1];
            o_lane.mid3 = '0;
        end
    end

endmodule

/* hdl/dxt1_palette.sv */
// Expands both 565 end colors, runs one lane per channel, merges into ARGB entries.
module dxt1_palette
    import dxt1_pkg::*;
(
    input  logic [15:0] i_color0,
    input  logic [15:0] i_color1,
    output t_palette    o_palette
);

    logic                                opaque;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]     ch0;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]     ch1;
    t_lane_out [NUM_CHAN-1:0]            lane_out;

    assign opaque = i_color0 > i_color1;

    // lane 2 = red, lane 1 = green, lane 0 = blue; plain shift, no replication
    assign ch0[2] = {i_color0[15:11], 3'b000};
    assign ch0[1] = {i_color0[10:5],  2'b00};
    assign ch0[0] = {i_color0[4:0],   3'b000};
    assign ch1[2] = {i_color1[15:11], 3'b000};
    assign ch1[1] = {i_color1[10:5],  2'b00};
    assign ch1[0] = {i_color1[4:0],   3'b000};

    for (genvar g = 0; g < NUM_CHAN; g++) begin : g_lane
        t_lane_in lane_in;
        assign lane_in.end0   = ch0[g];
        assign lane_in.end1   = ch1[g];
        assign lane_in.opaque = opaque;
        dxt1_lane u_lane (
            .i_lane (lane_in),
            .o_lane (lane_out[g])
        );
    end

    always_comb begin
        o_palette[0] = {ALPHA_OPAQUE, ch0[2], ch0[1], ch0[0]};
        o_palette[1] = {ALPHA_OPAQUE, ch1[2], ch1[1], ch1[0]};
        o_palette[2] = {ALPHA_OPAQUE, lane_out[2].mid2, lane_out[1].mid2, lane_out[0].mid2};
        if (opaque) begin
            o_palette[3] = {ALPHA_OPAQUE, lane_out[2].mid3, lane_out[1].mid3,
                            lane_out[0].mid3};
        end else begin
            o_palette[3] = '0;   // transparent black
        end
    end

endmodule

/* hdl/dxt1_block_decoder_unit.sv */
// Channel | Dir | Payload    | Transfer when
// in      | in  | t_in_item  | i_in_valid  && !o_in_stall  (one 64-bit block)
// out     | out | t_out_item | o_out_valid && !i_out_stall (one pixel)
// cfg     | in  | 13-bit reg | i_cfg_we (index 0 width, 1 height)
//
// Each block yields 16 pixels, one per cycle while the output does not stall,
// set by the single output register that pixels leave through.
// A taken block is held first; its first pixel then loads the output register.
// The next block is taken in the cycle its predecessor's last pixel loads.
// Reset (i_rst_n low, synchronous): dimensions 256x256, counters zero, empty.
// Output stall holds the pixel register; input stalls once a block is held.
// With fewer than four rows or columns a block is taken and dropped.
module dxt1_block_decoder_unit
    import dxt1_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    // block input
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    // pixel output
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data
);

    // configuration registers
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;

    // raster position of the next block
    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_row;
    logic [CNT_W-1:0] n_col;
    logic [CNT_W-1:0] n_row;

    // held block: palette, remaining indices, base position
    logic             r_blk_valid;
    t_palette         r_pal;
    logic [31:0]      r_idx;
    logic [CNT_W-1:0] r_blk_col;
    logic [CNT_W-1:0] r_blk_row;
    logic             r_end_img;
    logic [3:0]       r_pix;

    // output register
    logic             r_out_valid;
    t_out_item        r_out;

    logic [CFG_W-1:0] w_clamp;
    logic [CFG_W-1:0] h_clamp;
    logic [BLK_W-1:0] cols;
    logic [BLK_W-1:0] rows;
    logic             dims_ok;
    logic             end_row;
    logic             end_img;
    logic             in_xfer;
    logic             blk_load;
    logic             out_load;
    logic             blk_done;
    t_palette         palette;

    // floor to whole blocks, clamp to MAX_DIMENSION and to the counter range
    assign w_clamp = ({{(32-CFG_W){1'b0}}, r_width} > 32'(MAX_DIMENSION))
                     ? CFG_W'(MAX_DIMENSION) : r_width;
    assign h_clamp = ({{(32-CFG_W){1'b0}}, r_height} > 32'(MAX_DIMENSION))
                     ? CFG_W'(MAX_DIMENSION) : r_height;
    assign cols = (w_clamp[CFG_W-1:2] > BLK_LIMIT) ? BLK_LIMIT : w_clamp[CFG_W-1:2];
    assign rows = (h_clamp[CFG_W-1:2] > BLK_LIMIT) ? BLK_LIMIT : h_clamp[CFG_W-1:2];
    assign dims_ok = (cols != '0) && (rows != '0);

    assign end_row = ({1'b0, r_col} + BLK_W'(1)) >= cols;
    assign end_img = end_row && (({1'b0, r_row} + BLK_W'(1)) >= rows);

    always_comb begin
        if (end_row) begin
            n_col = '0;
            n_row = end_img ? '0 : r_row + CNT_W'(1);
        end else begin
            n_col = r_col + CNT_W'(1);
            n_row = r_row;
        end
    end

    // handshake: a new block may land as the last pixel of the held one leaves
    assign out_load   = r_blk_valid && (!r_out_valid || !i_out_stall);
    assign blk_done   = out_load && (r_pix == 4'd15);
    assign o_in_stall = r_blk_valid && !blk_done;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign blk_load   = in_xfer && dims_ok;

    // three channel lanes plus merge
    dxt1_palette u_palette (
        .i_color0  (i_in_data.color0),
        .i_color1  (i_in_data.color1),
        .o_palette (palette)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_RESET;
            r_height <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (blk_load) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // block holding stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_valid <= 1'b0;
            r_pix       <= '0;
        end else if (blk_load) begin
            r_blk_valid <= 1'b1;
            r_pix       <= '0;
        end else begin
            if (blk_done) begin
                r_blk_valid <= 1'b0;
            end
            if (out_load) begin
                r_pix <= r_pix + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (blk_load) begin
            r_pal     <= palette;
            r_idx     <= i_in_data.index_bits;
            r_blk_col <= r_col;
            r_blk_row <= r_row;
            r_end_img <= end_img;
        end else if (out_load) begin
            r_idx <= {2'b00, r_idx[31:2]};   // next pixel's index to the bottom
        end
    end

    // pixel output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.pixel_argb    <= r_pal[r_idx[1:0]];
            r_out.pixel_x       <= {r_blk_col, r_pix[1:0]};
            r_out.pixel_y       <= {r_blk_row, r_pix[3:2]};
            r_out.last_of_block <= (r_pix == 4'd15);
            r_out.last_of_image <= (r_pix == 4'd15) && r_end_img;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a nonzero pixel count only exists inside a held block
    a_pix_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pix != 4'd0) |-> r_blk_valid)
        else $error("pixel counter running without a held block");

    // a decodable block starts at pixel zero in the next cycle
    a_block_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blk_load |=> (r_blk_valid && (r_pix == 4'd0)))
        else $error("accepted block not loaded at pixel zero");

    // end of image is only flagged on a block's final pixel
    a_last_img: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last_of_image) |-> o_out_data.last_of_block)
        else $error("last_of_image without last_of_block");

endmodule
